### src/tsg_pkg.sv
// Package for the tone sequence generator: word types, command and status codes,
// and the constant function that builds the sine table contents.
// Used by every module of the block; depends on nothing.
package tsg_pkg;

  localparam int unsigned MAX_TONES_DEF   = 16;
  localparam int unsigned SINE_BITS_DEF   = 10;
  localparam int unsigned LENGTH_BITS_DEF = 24;

  // Taylor coefficients of sin(pi/2 * x) in Q2.30.
  localparam logic [63:0] SINE_A1 = 64'd1686629713;
  localparam logic [63:0] SINE_A3 = 64'd693598668;
  localparam logic [63:0] SINE_A5 = 64'd85569306;
  localparam logic [63:0] SINE_A7 = 64'd5026994;
  localparam logic [63:0] SINE_A9 = 64'd172272;
  localparam logic [63:0] SINE_FULL = 64'd32767;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_TICK  = 2'd3
  } tsg_cmd_e;

  typedef enum logic [1:0] {
    CODE_STOP = 2'd0,
    CODE_TONE = 2'd1,
    CODE_GAP  = 2'd2
  } tsg_code_e;

  typedef enum logic [0:0] {
    REG_TONE_COUNT  = 1'b0,
    REG_GAP_SAMPLES = 1'b1
  } tsg_reg_e;

  typedef struct packed {
    tsg_cmd_e    command;
    logic [3:0]  entry_index;
    logic [31:0] phase_step;
    logic [14:0] tone_amplitude;
    logic [23:0] tone_length;
  } tsg_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [1:0]         phase_code;
    logic [3:0]         tone_number;
  } tsg_out_t;

  // Per-sample side information that travels with the sine table read.
  typedef struct packed {
    logic        play;
    logic [14:0] amp;
    logic [1:0]  phase_code;
    logic [3:0]  tone_number;
  } tsg_side_t;

  // Odd Taylor series to x^9 by Horner in Q2.30, scaled to Q1.15 and capped.
  function automatic logic [15:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] y;
    x2 = (x * x) >> 30;
    t  = SINE_A9;
    t  = SINE_A7 - ((x2 * t) >> 30);
    t  = SINE_A5 - ((x2 * t) >> 30);
    t  = SINE_A3 - ((x2 * t) >> 30);
    t  = SINE_A1 - ((x2 * t) >> 30);
    y  = (x * t) >> 30;
    y  = (y * SINE_FULL + (64'd1 << 29)) >> 30;
    if (y > SINE_FULL) begin
      y = SINE_FULL;
    end
    return y[15:0];
  endfunction

  // Full-wave table entry k for a table of 2^sine_bits entries.
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned sine_bits);
    int unsigned qb;
    int unsigned quarter;
    int unsigned q;
    int unsigned r;
    int unsigned off;
    logic [63:0] x;
    logic [15:0] v;
    qb      = sine_bits - 2;
    quarter = 1 << qb;
    q       = k >> qb;
    r       = k & (quarter - 1);
    off     = ((q & 1) != 0) ? (quarter - r) : r;
    x       = 64'(off) << (30 - qb);
    v       = quarter_sine(x);
    return ((q & 2) != 0) ? $signed(-v) : $signed(v);
  endfunction

endpackage

### src/tsg_sequencer.sv
// Tone sequencer: command decode, tone table, configuration registers and the
// per-tick state machine that yields the sine table address and side data.
// Depends on tsg_pkg.
module tsg_sequencer #(
  parameter int unsigned MAX_TONES   = tsg_pkg::MAX_TONES_DEF,
  parameter int unsigned SINE_BITS   = tsg_pkg::SINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = tsg_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  tsg_pkg::tsg_in_t     word_i,
  input  logic                 cfg_we_i,
  input  tsg_pkg::tsg_reg_e    cfg_index_i,
  input  logic [23:0]          cfg_data_i,
  output logic                 emit_o,
  output logic [SINE_BITS-1:0] rom_addr_o,
  output tsg_pkg::tsg_side_t   side_o
);
  import tsg_pkg::*;

  localparam int unsigned ENT_W = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TONES + 1);
  localparam int unsigned CW    = CNT_W + 1;
  localparam int unsigned LEN_W = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;

  typedef enum logic [2:0] {
    MODE_STOP = 3'b001,
    MODE_TONE = 3'b010,
    MODE_GAP  = 3'b100
  } tsg_mode_e;

  typedef struct packed {
    logic [31:0]      step;
    logic [14:0]      amp;
    logic [LEN_W-1:0] len;
  } entry_t;

  entry_t           table_mem [MAX_TONES];
  entry_t           pf_q;
  entry_t           wr_entry;
  logic             wr_en;
  logic [ENT_W-1:0] wr_addr;
  logic [ENT_W-1:0] rd_addr;
  logic [CW-1:0]    rd_next;

  tsg_mode_e        mode_q, mode_d;
  logic             started_q, started_d;
  logic [ENT_W-1:0] cur_q, cur_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [31:0]      phase_q, phase_d;
  logic [31:0]      step_q, step_d;
  logic [14:0]      amp_q, amp_d;
  logic [4:0]       tone_count_q;
  logic [LEN_W-1:0] gap_q;

  logic [CNT_W-1:0] active_n;
  logic             last_tone;
  logic             do_next;
  logic             play;
  logic [1:0]       code;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_count_q <= '0;
      gap_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TONE_COUNT:  tone_count_q <= cfg_data_i[4:0];
        REG_GAP_SAMPLES: gap_q        <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A count register value beyond the table depth acts as the table depth.
  assign active_n  = (int'(tone_count_q) > MAX_TONES) ? CNT_W'(MAX_TONES)
                                                      : CNT_W'(tone_count_q);
  assign last_tone = (active_n == '0) ||
                     (started_q && ((CW'(cur_q) + CW'(1)) >= CW'(active_n)));

  assign wr_addr  = ENT_W'(word_i.entry_index);
  assign wr_entry = '{step: word_i.phase_step,
                      amp:  word_i.tone_amplitude,
                      len:  word_i.tone_length[LEN_W-1:0]};

  always_comb begin
    mode_d     = mode_q;
    started_d  = started_q;
    cur_d      = cur_q;
    left_d     = left_q;
    phase_d    = phase_q;
    step_d     = step_q;
    amp_d      = amp_q;
    wr_en      = 1'b0;
    emit_o     = 1'b0;
    do_next    = 1'b0;
    play       = 1'b0;
    rom_addr_o = phase_q[31 -: SINE_BITS];
    if (accept_i) begin
      unique case (word_i.command)
        CMD_LOAD: begin
          wr_en = (int'(word_i.entry_index) < MAX_TONES);
        end
        CMD_START: begin
          mode_d    = MODE_GAP;
          started_d = 1'b0;
          cur_d     = '0;
          left_d    = '0;
        end
        CMD_STOP: begin
          mode_d = MODE_STOP;
        end
        CMD_TICK: begin
          if (mode_q != MODE_STOP) begin
            emit_o = 1'b1;
            if (left_q == '0) begin
              unique case (mode_q)
                MODE_TONE: begin
                  if (gap_q == '0) begin
                    do_next = 1'b1;
                  end else begin
                    mode_d = MODE_GAP;
                    left_d = gap_q;
                  end
                end
                MODE_GAP: do_next = 1'b1;
                default: ;
              endcase
            end
            if (do_next) begin
              if (last_tone) begin
                mode_d = MODE_STOP;
              end else begin
                cur_d     = started_q ? (cur_q + ENT_W'(1)) : '0;
                started_d = 1'b1;
                step_d    = pf_q.step;
                amp_d     = pf_q.amp;
                if (mode_q != MODE_TONE) begin
                  phase_d = '0;
                end
                left_d = pf_q.len;
                mode_d = MODE_TONE;
              end
            end
            play       = (left_d != '0) && (mode_d == MODE_TONE);
            rom_addr_o = phase_d[31 -: SINE_BITS];
            if (play) begin
              phase_d = phase_d + step_d;
            end
            if (left_d != '0) begin
              left_d = left_d - LEN_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mode_d)
      MODE_TONE: code = CODE_TONE;
      MODE_GAP:  code = CODE_GAP;
      default:   code = CODE_STOP;
    endcase
  end

  assign side_o = '{play:        play,
                    amp:         amp_d,
                    phase_code:  code,
                    tone_number: started_d ? 4'(cur_d) : 4'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_STOP;
      started_q <= 1'b0;
      cur_q     <= '0;
      left_q    <= '0;
      phase_q   <= '0;
      step_q    <= '0;
      amp_q     <= '0;
    end else begin
      mode_q    <= mode_d;
      started_q <= started_d;
      cur_q     <= cur_d;
      left_q    <= left_d;
      phase_q   <= phase_d;
      step_q    <= step_d;
      amp_q     <= amp_d;
    end
  end

  // The entry that the next tone change would use is prefetched into a register,
  // with a load to that same entry forwarded straight into the fetch register.
  assign rd_next = CW'(cur_d) + CW'(1);
  assign rd_addr = (!started_d || (rd_next >= CW'(MAX_TONES))) ? '0 : ENT_W'(rd_next);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_entry;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      pf_q <= wr_entry;
    end else begin
      pf_q <= table_mem[rd_addr];
    end
  end

endmodule

### src/tsg_sine_stage.sv
// Sine table stage: full-wave sine ROM with registered read and the matching
// side-data register. Depends on tsg_pkg.
module tsg_sine_stage #(
  parameter int unsigned SINE_BITS = tsg_pkg::SINE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  output logic                 ready_o,
  input  logic                 emit_i,
  input  logic [SINE_BITS-1:0] addr_i,
  input  tsg_pkg::tsg_side_t   side_i,
  output logic                 valid_o,
  output tsg_pkg::tsg_side_t   side_o,
  output logic signed [15:0]   sine_o
);
  import tsg_pkg::*;

  localparam int unsigned ROM_SIZE = 1 << SINE_BITS;

  typedef logic signed [15:0] rom_t [ROM_SIZE];

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned k = 0; k < ROM_SIZE; k++) begin
      r[k] = sine_entry(k, SINE_BITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic               valid_q;
  tsg_side_t          side_q;
  logic signed [15:0] sine_q;

  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      side_q <= side_i;
      sine_q <= SINE_ROM[addr_i];
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign sine_o  = sine_q;

endmodule

### src/tsg_scaler.sv
// Output stage: amplitude multiply, round half up, saturation to Q1.15, and
// the output word register. Depends on tsg_pkg.
module tsg_scaler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  tsg_pkg::tsg_side_t side_i,
  input  logic signed [15:0] sine_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsg_pkg::tsg_out_t  out_word_o
);
  import tsg_pkg::*;

  localparam logic signed [31:0] ROUND_HALF = 32'sd16384;
  localparam logic signed [16:0] SAT_HI     = 17'sd32767;
  localparam logic signed [16:0] SAT_LO     = -17'sd32768;

  logic               out_valid_q;
  tsg_out_t           out_q;
  tsg_out_t           out_d;
  logic signed [31:0] prod;
  logic signed [31:0] rounded;
  logic signed [16:0] scaled;
  logic signed [15:0] sat;

  assign prod    = $signed({1'b0, side_i.amp}) * sine_i;
  assign rounded = prod + ROUND_HALF;
  // Dropping the low bits of a two's complement value floors it.
  assign scaled  = rounded[31:15];

  always_comb begin
    if (scaled > SAT_HI) begin
      sat = SAT_HI[15:0];
    end else if (scaled < SAT_LO) begin
      sat = SAT_LO[15:0];
    end else begin
      sat = scaled[15:0];
    end
    out_d.sample      = side_i.play ? sat : 16'sd0;
    out_d.phase_code  = side_i.phase_code;
    out_d.tone_number = side_i.tone_number;
  end

  assign free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (free_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### src/tone_sequence_generator.sv
// Tone sequence generator top level: sequencer, sine table stage and output
// scaler. Depends on tsg_pkg, tsg_sequencer, tsg_sine_stage and tsg_scaler.
//
// Usage: input words arrive on in_valid_i/in_ready_o/in_word_i. A load word
// writes one tone entry, a start word arms the test, a stop word halts it and
// a tick word asks for one audio sample. Only a tick while the test runs
// yields an output word on out_valid_o/out_ready_i/out_word_o; loads, starts,
// stops and ticks while stopped yield none.
// Throughput is one input word per cycle while in_ready_o is high. A tick's
// output word passes through the state update and registered sine table read,
// then the amplitude multiply and saturation into the output register.
// The tone count and gap length registers are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write them only while the block
// is idle, since the block itself does not enforce this.
// Reset clears the test to stopped and empties both pipeline stages; the tone
// table holds whatever it held until entries are loaded.
// When the receiver stalls, the output word holds, the sine stage holds a
// second word, and in_ready_o drops only once both are full.
module tone_sequence_generator #(
  parameter int unsigned MAX_TONES   = tsg_pkg::MAX_TONES_DEF,
  parameter int unsigned SINE_BITS   = tsg_pkg::SINE_BITS_DEF,
  parameter int unsigned LENGTH_BITS = tsg_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsg_pkg::tsg_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tsg_pkg::tsg_out_t out_word_o,
  input  logic              cfg_we_i,
  input  tsg_pkg::tsg_reg_e cfg_index_i,
  input  logic [23:0]       cfg_data_i
);
  import tsg_pkg::*;

  logic                 accept;
  logic                 emit;
  logic [SINE_BITS-1:0] rom_addr;
  tsg_side_t            seq_side;
  tsg_side_t            stage_side;
  logic                 stage_valid;
  logic signed [15:0]   stage_sine;
  logic                 scaler_free;

  // The state update happens at acceptance; only the sample path can stall.
  assign accept = in_valid_i && in_ready_o;

  tsg_sequencer #(
    .MAX_TONES  (MAX_TONES),
    .SINE_BITS  (SINE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .word_i     (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .emit_o     (emit),
    .rom_addr_o (rom_addr),
    .side_o     (seq_side)
  );

  tsg_sine_stage #(
    .SINE_BITS(SINE_BITS)
  ) u_sine_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(scaler_free),
    .ready_o  (in_ready_o),
    .emit_i   (emit),
    .addr_i   (rom_addr),
    .side_i   (seq_side),
    .valid_o  (stage_valid),
    .side_o   (stage_side),
    .sine_o   (stage_sine)
  );

  tsg_scaler u_scaler (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (stage_valid),
    .side_i     (stage_side),
    .sine_i     (stage_sine),
    .free_o     (scaler_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

### src/tsg_checker.sv
// Port-level checker for the tone sequence generator, bound to the top level.
// Depends on tsg_pkg and tone_sequence_generator.
module tsg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input tsg_pkg::tsg_in_t  in_word_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input tsg_pkg::tsg_out_t out_word_o
);
  import tsg_pkg::*;

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // Input backpressure only comes from a stalled, full output side.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input not ready without an output stall");

  // Silence and the stopping sample are always zero.
  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.phase_code != CODE_TONE) |-> out_word_o.sample == 16'sd0)
    else $error("nonzero sample outside a tone");

  // With the output register empty, the input side is always ready.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input not ready with the output empty");

endmodule

bind tone_sequence_generator tsg_checker u_tsg_checker (.*);

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tone_sequence_generator: drives command words,
// predicts every audio sample and checks each output word against it.
// Depends on tsg_pkg and the tone_sequence_generator RTL only.

module tb;
  import tsg_pkg::*;

  // Ten phase-step bits index the sine table; sixteen tone entries.
  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned TABLE_SIZE   = 1024;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_WORDS  = 62;
  localparam int unsigned PRINT_LIMIT  = 30;
  // The limit lies far beyond the slowest correct run.
  localparam realtime     RUN_LIMIT    = 200000 * 12ns;

  // Which fields of one output word disagreed with the prediction.
  typedef struct packed {
    bit orphan;
    bit sample;
    bit code;
    bit tone;
  } sample_miss_t;

  // The scoreboard keeps its own copy of the sequencer state and the two
  // registers, advances it for every accepted input word, and queues the
  // output word that each tick should produce.
  class tone_scoreboard;
    logic signed [15:0] sine_tab [TABLE_SIZE];
    logic [31:0]        step_tab [ENTRIES];
    logic [14:0]        amp_tab  [ENTRIES];
    logic [23:0]        len_tab  [ENTRIES];
    tsg_code_e          mode;
    bit                 started;
    int unsigned        cur;
    logic [23:0]        left;
    logic [31:0]        acc;
    logic [31:0]        cur_step;
    logic [14:0]        cur_amp;
    logic [4:0]         count_reg;
    logic [23:0]        gap_reg;
    tsg_out_t           pending [$];
    int unsigned        checked;

    function new();
      for (int k = 0; k < TABLE_SIZE; k++) begin
        sine_tab[k] = table_value(k);
      end
      for (int i = 0; i < ENTRIES; i++) begin
        step_tab[i] = '0;
        amp_tab[i]  = '0;
        len_tab[i]  = '0;
      end
      mode      = CODE_STOP;
      started   = 1'b0;
      cur       = 0;
      left      = '0;
      acc       = '0;
      cur_step  = '0;
      cur_amp   = '0;
      count_reg = '0;
      gap_reg   = '0;
      checked   = 0;
    endfunction

    // Odd power series of sin(pi/2 * x) in Q2.30, Horner form, to Q1.15.
    function longint unsigned quarter_wave(longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned y;
      x2 = (x * x) >> 30;
      t  = 64'd172272;
      t  = 64'd5026994    - ((x2 * t) >> 30);
      t  = 64'd85569306   - ((x2 * t) >> 30);
      t  = 64'd693598668  - ((x2 * t) >> 30);
      t  = 64'd1686629713 - ((x2 * t) >> 30);
      y  = (x * t) >> 30;
      y  = (y * 64'd32767 + (64'd1 << 29)) >> 30;
      if (y > 64'd32767) begin
        y = 64'd32767;
      end
      return y;
    endfunction

    function logic signed [15:0] table_value(int unsigned k);
      int unsigned     q;
      int unsigned     r;
      int unsigned     off;
      longint unsigned v;
      q   = k / (TABLE_SIZE / 4);
      r   = k % (TABLE_SIZE / 4);
      off = (q & 1) ? (TABLE_SIZE / 4 - r) : r;
      v   = quarter_wave(longint'(off) << 22);
      return (q & 2) ? -16'(v) : 16'(v);
    endfunction

    function void set_reg(tsg_reg_e idx, logic [23:0] value);
      if (idx == REG_TONE_COUNT) begin
        count_reg = value[4:0];
      end else begin
        gap_reg = value;
      end
    endfunction

    // Move to the next entry, or stop when the list is used up.
    function void next_entry();
      int unsigned n;
      n = (count_reg > ENTRIES) ? ENTRIES : count_reg;
      if (n == 0 || (started && cur >= n - 1)) begin
        mode = CODE_STOP;
        return;
      end
      cur      = started ? cur + 1 : 0;
      started  = 1'b1;
      cur_step = step_tab[cur];
      cur_amp  = amp_tab[cur];
      // Phase is continuous only from tone straight into tone.
      if (mode != CODE_TONE) begin
        acc = '0;
      end
      left = len_tab[cur];
      mode = CODE_TONE;
    endfunction

    function void note_word(tsg_in_t w);
      longint   prod;
      longint   scaled;
      tsg_out_t want;
      case (w.command)
        CMD_LOAD: begin
          step_tab[w.entry_index] = w.phase_step;
          amp_tab[w.entry_index]  = w.tone_amplitude;
          len_tab[w.entry_index]  = w.tone_length;
        end
        CMD_START: begin
          mode    = CODE_GAP;
          started = 1'b0;
          cur     = 0;
          left    = '0;
        end
        CMD_STOP: begin
          mode = CODE_STOP;
        end
        default: begin
          if (mode != CODE_STOP) begin
            if (left == 0) begin
              if (mode == CODE_TONE) begin
                if (gap_reg == 0) begin
                  next_entry();
                end else begin
                  mode = CODE_GAP;
                  left = gap_reg;
                end
              end else begin
                next_entry();
              end
            end
            scaled = 0;
            if (left > 0 && mode == CODE_TONE) begin
              prod   = longint'(cur_amp) * longint'(sine_tab[acc[31:22]]);
              scaled = (prod + 16384) >>> 15;
              if (scaled > 32767) begin
                scaled = 32767;
              end
              if (scaled < -32768) begin
                scaled = -32768;
              end
              acc = acc + cur_step;
            end
            if (left > 0) begin
              left = left - 1;
            end
            want.sample      = 16'(scaled);
            want.phase_code  = mode;
            want.tone_number = started ? 4'(cur) : 4'd0;
            pending.push_back(want);
          end
        end
      endcase
    endfunction

    function sample_miss_t check_sample(tsg_out_t got, output tsg_out_t want);
      sample_miss_t miss;
      miss = '0;
      want = '0;
      if (pending.size() == 0) begin
        miss.orphan = 1'b1;
        return miss;
      end
      want    = pending.pop_front();
      checked = checked + 1;
      miss.sample = (got.sample !== want.sample);
      miss.code   = (got.phase_code !== want.phase_code);
      miss.tone   = (got.tone_number !== want.tone_number);
      return miss;
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  tsg_in_t           in_word_i;
  logic              out_valid_o;
  logic              out_ready_i;
  tsg_out_t          out_word_o;
  logic              cfg_we_i;
  tsg_reg_e          cfg_index_i;
  logic [23:0]       cfg_data_i;

  tone_scoreboard    model;
  int unsigned       mismatch_count;
  int unsigned       words_sent [4];
  int unsigned       settings_used;
  bit                tx_lazy;
  bit                rx_lazy;
  bit                rx_hold;
  bit                pressure_go;

  tone_sequence_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Every mismatch goes through here; printing stops after a while so that
  // a systematic fault does not flood the log, but counting goes on.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("tb: mismatch at %0t: %s", $realtime, what);
    end
  endtask

  function automatic tsg_in_t make_word(tsg_cmd_e cmd, logic [3:0] idx, logic [31:0] step,
                                        logic [14:0] amp, logic [23:0] len);
    tsg_in_t w;
    w.command        = cmd;
    w.entry_index    = idx;
    w.phase_step     = step;
    w.tone_amplitude = amp;
    w.tone_length    = len;
    return w;
  endfunction

  // Random word: mostly ticks, with loads, restarts and stops mixed in.
  // Tones are short as a rule so that whole lists play out, and now and
  // then a full 24-bit length keeps one tone going for the rest of a phase.
  function automatic tsg_in_t random_word();
    tsg_in_t     w;
    int unsigned pick;
    w.entry_index = 4'($urandom_range(0, ENTRIES - 1));
    w.phase_step  = ($urandom_range(0, 3) == 0) ? ($urandom >> $urandom_range(0, 31))
                                                : $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      w.tone_amplitude = '0;
    end else if (pick == 1) begin
      w.tone_amplitude = 15'h7fff;
    end else begin
      w.tone_amplitude = 15'($urandom_range(0, 32767));
    end
    w.tone_length = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6));
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.command = CMD_LOAD;
    end else if (pick < 13) begin
      w.command = CMD_START;
    end else if (pick < 16) begin
      w.command = CMD_STOP;
    end else begin
      w.command = CMD_TICK;
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until it is taken. Valid
  // stays high between back-to-back words.
  task automatic send_word(input tsg_in_t w);
    int unsigned pause;
    pause = tx_lazy ? $urandom_range(0, 8) : 0;
    if (pause > 0) begin
      in_valid_i <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    model.note_word(w);
    words_sent[w.command]++;
  endtask

  // Let every expected word come out, then give the pipeline time to finish
  // words that produce nothing before the registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [4:0] count, input logic [23:0] gap);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TONE_COUNT;
    cfg_data_i  <= 24'(count);
    @(posedge clk_i);
    model.set_reg(REG_TONE_COUNT, 24'(count));
    cfg_index_i <= REG_GAP_SAMPLES;
    cfg_data_i  <= gap;
    @(posedge clk_i);
    model.set_reg(REG_GAP_SAMPLES, gap);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Receiver: takes output words with random stalls after each one, and
  // drops ready entirely while the pressure hold is on.
  initial begin
    int unsigned  stall;
    tsg_out_t     want;
    sample_miss_t miss;
    stall       = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        miss = model.check_sample(out_word_o, want);
        if (miss.orphan) begin
          report_mismatch($sformatf("output word with no tick waiting: sample %0d code %0d",
                                    out_word_o.sample, out_word_o.phase_code));
        end
        if (miss.sample) begin
          report_mismatch($sformatf("sample %0d, expected %0d",
                                    out_word_o.sample, want.sample));
        end
        if (miss.code) begin
          report_mismatch($sformatf("phase code %0d, expected %0d",
                                    out_word_o.phase_code, want.phase_code));
        end
        if (miss.tone) begin
          report_mismatch($sformatf("tone number %0d, expected %0d",
                                    out_word_o.tone_number, want.tone_number));
        end
        stall = rx_lazy ? $urandom_range(0, 8) : 0;
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !rx_hold;
      end
    end
  end

  // Pressure: once asked, the receiver is held off for a long stretch so
  // that both pipeline stages fill and the block stalls its input.
  initial begin
    rx_hold = 1'b0;
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  // Main sequence: reset, a directed walk through the special cases, then
  // several phases of random words under different register settings.
  initial begin
    logic [4:0]  count;
    logic [23:0] gap;
    model          = new();
    mismatch_count = 0;
    settings_used  = 0;
    for (int i = 0; i < 4; i++) begin
      words_sent[i] = 0;
    end
    tx_lazy     = 1'b1;
    rx_lazy     = 1'b1;
    pressure_go = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_TONE_COUNT;
    cfg_data_i  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Three back-to-back tones with no gap: a quarter-turn
    // step at full amplitude, a zero-length tone, and a step of all ones.
    // The fourth entry carries the remaining extremes but is not played.
    set_config(5'd3, 24'd0);
    send_word(make_word(CMD_LOAD, 4'd0, 32'h4000_0000, 15'h7fff, 24'd3));
    send_word(make_word(CMD_LOAD, 4'd1, 32'h0000_0000, 15'h0000, 24'd0));
    send_word(make_word(CMD_LOAD, 4'd2, 32'hffff_ffff, 15'h7fff, 24'd2));
    send_word(make_word(CMD_LOAD, 4'd15, 32'h8000_0000, 15'h0001, 24'hff_ffff));
    // Stop and tick while stopped change nothing and produce nothing.
    send_word(make_word(CMD_STOP, 4'd0, '0, '0, '0));
    send_word(make_word(CMD_TICK, 4'd0, '0, '0, '0));
    // Play the whole list; the tick that runs out of tones reports stopped.
    send_word(make_word(CMD_START, 4'd0, '0, '0, '0));
    repeat (8) send_word(make_word(CMD_TICK, 4'd0, '0, '0, '0));
    // A start while running restarts from entry zero at phase zero.
    send_word(make_word(CMD_START, 4'd0, '0, '0, '0));
    send_word(make_word(CMD_TICK, 4'd0, '0, '0, '0));
    send_word(make_word(CMD_START, 4'd0, '0, '0, '0));
    send_word(make_word(CMD_TICK, 4'd0, '0, '0, '0));
    // With a tone count of zero the first tick after a start stops at once.
    set_config(5'd0, 24'd1);
    send_word(make_word(CMD_START, 4'd0, '0, '0, '0));
    send_word(make_word(CMD_TICK, 4'd0, '0, '0, '0));
    send_word(make_word(CMD_TICK, 4'd0, '0, '0, '0));

    // Random phases. The first one loads every entry so that no tone ever
    // comes from an entry that was never written. The test is left running
    // across phase boundaries, so a smaller count can cut a list short.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin count = 5'd16; gap = 24'd0;        end
        1: begin count = 5'd5;  gap = 24'd2;        end
        2: begin count = 5'd31; gap = 24'd1;        end
        3: begin count = 5'd1;  gap = 24'd0;        end
        4: begin count = 5'd16; gap = 24'hff_ffff;  end
        5: begin count = 5'd0;  gap = 24'd3;        end
        6: begin count = 5'($urandom_range(0, 31)); gap = 24'($urandom); end
        default: begin
          count = 5'($urandom_range(0, 31));
          gap   = 24'($urandom_range(0, 5));
        end
      endcase
      // A stretch without idling on either side, used for the pressure test.
      tx_lazy = (ph != 2) && (ph != 6);
      rx_lazy = (ph != 2) && (ph != 5);
      set_config(count, gap);
      if (ph == 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          tsg_in_t w;
          w             = random_word();
          w.command     = CMD_LOAD;
          w.entry_index = 4'(i);
          send_word(w);
        end
      end
      send_word(make_word(CMD_START, 4'd0, '0, '0, '0));
      if (ph == 2) begin
        pressure_go = 1'b1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_word(random_word());
      end
    end

    in_valid_i <= 1'b0;
    while (model.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("tb: %0d ticks, %0d loads, %0d starts, %0d stops under %0d register settings",
             words_sent[CMD_TICK], words_sent[CMD_LOAD], words_sent[CMD_START],
             words_sent[CMD_STOP], settings_used);
    $display("tb: %0d output words checked, %0d mismatches", model.checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
